// ===== design/swm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types, constants and symbol tables of the symmetric 3x3 matcher.
// ----------------------------------------------------------------------------
package swm_pkg;

   // Sizes
   localparam int ID_BITS    = 16;
   localparam int CELLS      = 8;
   localparam int VARIANTS   = 16;
   localparam int CODE_W     = 2 * CELLS;
   localparam int TABLE_SIZE = 1 << CODE_W;
   localparam int ENTRY_W    = ID_BITS + 1;
   localparam int MATCH_W    = 16;

   // Opcodes
   localparam logic [1:0] OP_CLEAR    = 2'd0;
   localparam logic [1:0] OP_REGISTER = 2'd1;
   localparam logic [1:0] OP_LOOKUP   = 2'd2;

   // Symbol that marks a bad pattern
   localparam logic [2:0] SYM_INVALID = 3'd7;

   // Cell permutations for one rotation and for the mirror
   localparam logic [2:0] ROT_MAP  [CELLS] = '{3'd2, 3'd4, 3'd7, 3'd1, 3'd6, 3'd0, 3'd3, 3'd5};
   localparam logic [2:0] FLIP_MAP [CELLS] = '{3'd2, 3'd1, 3'd0, 3'd4, 3'd3, 3'd7, 3'd6, 3'd5};

   // Allowed cell values per symbol, bit c set when cell value c matches
   localparam logic [3:0] SYM_CELLS [8] = '{4'h2, 4'h4, 4'h1, 4'h3, 4'h5, 4'h7, 4'h8, 4'h0};
   // Symbol under black/white swap
   localparam logic [2:0] SYM_SWAP  [8] = '{3'd1, 3'd0, 3'd2, 3'd4, 3'd3, 3'd5, 3'd6, 3'd7};

   // Channel words
   typedef struct packed {
      logic [1:0]  opcode;
      logic [23:0] shape_code;
      logic [15:0] shape_tag;
      logic [15:0] neighborhood;
   } req_type;

   typedef struct packed {
      logic [MATCH_W-1:0] match_id;
      logic               matched;
      logic               symbol_error;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic go_sweep;
      logic sweep;
      logic sweep_clear;
      logic push_done;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic sym_bad;
      logic sweep_last;
   } ctrl_status_type;

   // Allowed-cell masks of every symmetry variant
   typedef logic [VARIANTS-1:0][CELLS-1:0][3:0] mask_set_type;

   // Build the masks of all 16 variants of a wildcard pattern
   function automatic mask_set_type variant_masks(input logic [23:0] code);
      mask_set_type m;
      logic [2:0]   s [CELLS];
      logic [2:0]   t [CELLS];
      logic [3:0]   v4;
      m = '0;
      for (int v = 0; v < VARIANTS; v++) begin
         v4 = 4'(v);
         for (int i = 0; i < CELLS; i++) begin
            s[i] = v4[3] ? SYM_SWAP[code[3*i +: 3]] : code[3*i +: 3];
         end
         if (v4[2]) begin
            for (int i = 0; i < CELLS; i++) t[i] = s[FLIP_MAP[i]];
            for (int i = 0; i < CELLS; i++) s[i] = t[i];
         end
         for (int k = 0; k < 3; k++) begin
            if (2'(k) < v4[1:0]) begin
               for (int i = 0; i < CELLS; i++) t[i] = s[ROT_MAP[i]];
               for (int i = 0; i < CELLS; i++) s[i] = t[i];
            end
         end
         for (int i = 0; i < CELLS; i++) m[v][i] = SYM_CELLS[s[i]];
      end
      return m;
   endfunction

endpackage
`default_nettype wire

// ===== design/swm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module swm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== design/swm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swm_ctrl
// Controller: accepts words, starts table sweeps and ends them.
// ----------------------------------------------------------------------------
module swm_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [1:0]               opcode,
   input  wire swm_pkg::ctrl_status_type status,
   output logic                          busy,
   output swm_pkg::ctrl_cmd_type         cmd
);
   import swm_pkg::*;

   typedef enum logic {ST_IDLE, ST_SWEEP} state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      clear_kind_ff, clear_kind_in;
   logic      report_ff, report_in;
   logic      accept, go_sweep, sweep_end;

   // Decode the incoming word
   always_comb begin
      accept    = start & ~busy_ff;
      go_sweep  = accept & ((opcode == OP_CLEAR) |
                            ((opcode == OP_REGISTER) & ~status.sym_bad));
      sweep_end = (state_ff == ST_SWEEP) & status.sweep_last;
   end

   // Next state
   always_comb begin
      state_in      = state_ff;
      busy_in       = busy_ff;
      clear_kind_in = clear_kind_ff;
      report_in     = report_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (go_sweep) begin
               state_in      = ST_SWEEP;
               busy_in       = 1'b1;
               clear_kind_in = (opcode == OP_CLEAR);
               report_in     = 1'b1;
            end
         end
         ST_SWEEP: begin
            if (sweep_end) begin
               state_in = ST_IDLE;
               busy_in  = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
            busy_in  = 1'b0;
         end
      endcase
   end

   // Hold state; reset starts a silent clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         busy_ff       <= 1'b1;
         clear_kind_ff <= 1'b1;
         report_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         busy_ff       <= busy_in;
         clear_kind_ff <= clear_kind_in;
         report_ff     <= report_in;
      end
   end

   // Drive commands
   always_comb begin
      cmd.accept      = accept;
      cmd.go_sweep    = go_sweep;
      cmd.sweep       = (state_ff == ST_SWEEP);
      cmd.sweep_clear = clear_kind_ff;
      cmd.push_done   = sweep_end & report_ff;
   end

   assign busy = busy_ff;

endmodule
`default_nettype wire

// ===== design/swm_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swm_datapath
// Datapath: pattern table, sweep counter, variant match and result stage.
// ----------------------------------------------------------------------------
module swm_datapath (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire swm_pkg::ctrl_cmd_type    cmd,
   input  wire swm_pkg::req_type         req_word,
   output swm_pkg::ctrl_status_type      status,
   output logic                          rsp_strobe,
   output swm_pkg::rsp_type              rsp_word
);
   import swm_pkg::*;

   logic [CODE_W-1:0]  cnt_ff, cnt_in;
   mask_set_type       mask_ff;
   logic [ID_BITS-1:0] id_ff;
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_lookup_ff, s1_lookup_in;
   logic               s1_err_ff, s1_err_in;
   logic               strobe_ff;
   rsp_type            rsp_ff, rsp_in;
   logic               sym_bad;
   logic               hit;
   logic               var_ok;
   logic               wr_en, rd_en;
   logic [ENTRY_W-1:0] wr_data, rd_data;

   // Flag an invalid symbol in the incoming pattern
   always_comb begin
      sym_bad = 1'b0;
      for (int i = 0; i < CELLS; i++) begin
         if (req_word.shape_code[3*i +: 3] == SYM_INVALID) sym_bad = 1'b1;
      end
   end

   // Match the sweep code against every variant
   always_comb begin
      hit = 1'b0;
      for (int v = 0; v < VARIANTS; v++) begin
         var_ok = 1'b1;
         for (int i = 0; i < CELLS; i++) begin
            var_ok = var_ok & mask_ff[v][i][cnt_ff[2*i +: 2]];
         end
         hit = hit | var_ok;
      end
   end

   // Table write and lookup read
   always_comb begin
      wr_en   = cmd.sweep & (cmd.sweep_clear | hit);
      wr_data = cmd.sweep_clear ? '0 : {1'b1, id_ff};
      rd_en   = cmd.accept & (req_word.opcode == OP_LOOKUP);
   end

   swm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_SIZE)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (req_word.neighborhood),
      .rd_data (rd_data)
   );

   // Advance the sweep counter and queue the result word
   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.go_sweep) begin
         cnt_in = '0;
      end else if (cmd.sweep) begin
         cnt_in = cnt_ff + 1'b1;
      end
      s1_valid_in  = (cmd.accept & ~cmd.go_sweep) | cmd.push_done;
      s1_lookup_in = rd_en;
      s1_err_in    = cmd.accept & (req_word.opcode == OP_REGISTER) & sym_bad;
      rsp_in.matched      = s1_lookup_ff & rd_data[ID_BITS];
      rsp_in.match_id     = rsp_in.matched ? MATCH_W'(rd_data[ID_BITS-1:0]) : '0;
      rsp_in.symbol_error = s1_err_ff;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         s1_valid_ff <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         cnt_ff      <= cnt_in;
         s1_valid_ff <= s1_valid_in;
         strobe_ff   <= s1_valid_ff;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.go_sweep) begin
         mask_ff <= variant_masks(req_word.shape_code);
         id_ff   <= ID_BITS'(req_word.shape_tag);
      end
      s1_lookup_ff <= s1_lookup_in;
      s1_err_ff    <= s1_err_in;
      rsp_ff       <= rsp_in;
   end

   always_comb begin
      status.sym_bad    = sym_bad;
      status.sweep_last = &cnt_ff;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_word   = rsp_ff;

endmodule
`default_nettype wire

// ===== design/symmetric_wildcard_3x3_matcher.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// symmetric_wildcard_3x3_matcher
// 3x3 neighborhood pattern table with symmetric wildcard registration.
// ----------------------------------------------------------------------------
// Usage:
//   A request word is taken at a clock edge where start is high and busy is
//   low. Each request gives exactly one response word on rsp_word, shown for
//   one cycle with rsp_strobe high; the receiver cannot stall it.
//   Look up: table read and response are registered; look-ups and other
//     words that need no table sweep are taken one per cycle.
//   Clear and valid register: a sweep over all 65536 table entries, one
//     entry per cycle through the single write port; busy is high during the
//     sweep, and the response word is registered after the last write.
//   Register with an invalid symbol, or the unused opcode: no table change,
//     and a response as for a look-up.
//   Reset: a silent clearing sweep over all 65536 table entries, busy high meanwhile.
//   Responses leave in request order.
// ----------------------------------------------------------------------------
module symmetric_wildcard_3x3_matcher (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire swm_pkg::req_type req_word,
   output logic                  rsp_strobe,
   output swm_pkg::rsp_type      rsp_word
);
   import swm_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   swm_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .opcode (req_word.opcode),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   swm_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_word   (req_word),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   // A taken look-up is answered with rsp_strobe
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_word.opcode == OP_LOOKUP) |=> ##1 rsp_strobe)
      else $error("look-up response missing");

   // A taken clear starts a sweep
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_word.opcode == OP_CLEAR) |=> busy)
      else $error("clear did not raise busy");

   // A sweep is only entered through a taken word
   assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("sweep started without a request");

endmodule
`default_nettype wire

// ===== bench/symmetric_wildcard_3x3_matcher_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// symmetric_wildcard_3x3_matcher_tb
// Self-checking bench for the 3x3 pattern table. A mirror of the table
// expands each registered wildcard pattern over its sixteen rotations,
// mirrors and color swaps. Every response word is checked in order against
// the word predicted when its request was taken. Requests arrive in random
// bursts: a short directed opening, then random look-ups, about half of them
// aimed at registered patterns, with a few table sweeps spread across the run.
// ----------------------------------------------------------------------------
module symmetric_wildcard_3x3_matcher_tb;
   import swm_pkg::*;

   localparam logic [1:0]  OP_UNUSED      = 2'd3;
   localparam int          RANDOM_WORDS   = 1500;
   localparam int          SWEEP_SPACING  = 250;
   localparam int          CLEAR_SLOT     = 875;
   localparam int          CYCLE_LIMIT    = 4_000_000;
   localparam int          DRAIN_CYCLES   = 16;
   localparam int          REPORT_MAX     = 10;
   localparam logic [23:0] PAT_ALL_ANY    = 24'hB6DB6D;
   localparam logic [23:0] PAT_ALL_BORDER = 24'hDB6DB6;
   localparam logic [23:0] PAT_MIXED      = 24'h7AC688;

   // Grid permutations, entry i at bits 3i: one quarter turn and the mirror
   localparam logic [23:0] TURN_MAP = {3'd5, 3'd3, 3'd0, 3'd6, 3'd1, 3'd7, 3'd4, 3'd2};
   localparam logic [23:0] MIRROR_MAP = {3'd5, 3'd6, 3'd7, 3'd3, 3'd4, 3'd0, 3'd1, 3'd2};
   // Symbol under black/white swap, entry s at bits 3s
   localparam logic [23:0] COLOR_SWAP = {3'd7, 3'd6, 3'd5, 3'd3, 3'd4, 3'd2, 3'd0, 3'd1};
   // Cell values each symbol admits, entry s at bits 4s, bit c for cell c
   localparam logic [31:0] SYMBOL_CELLS = 32'h08753142;

   // Mirror of the pattern table and the answers still owed by the block
   class pattern_table_mirror;
      bit        entry_valid [TABLE_SIZE];
      bit [15:0] entry_id    [TABLE_SIZE];
      rsp_type   awaited_answers [$];
      int        mismatches;
      int        answers_checked;
      int        hits;
      int        rejected;
      int        op_count [4];

      // Allowed-cell masks of one symmetry variant, position i at bits 4i
      function bit [31:0] variant_cells(bit [23:0] code, int v);
         bit [23:0] sym;
         bit [23:0] moved;
         bit [31:0] masks;
         sym = code;
         if (v[3]) begin
            for (int i = 0; i < 8; i++) sym[3*i +: 3] = COLOR_SWAP[3*sym[3*i +: 3] +: 3];
         end
         if (v[2]) begin
            for (int i = 0; i < 8; i++) moved[3*i +: 3] = sym[3*MIRROR_MAP[3*i +: 3] +: 3];
            sym = moved;
         end
         for (int r = 0; r < v[1:0]; r++) begin
            for (int i = 0; i < 8; i++) moved[3*i +: 3] = sym[3*TURN_MAP[3*i +: 3] +: 3];
            sym = moved;
         end
         for (int i = 0; i < 8; i++) masks[4*i +: 4] = SYMBOL_CELLS[4*sym[3*i +: 3] +: 4];
         return masks;
      endfunction

      function int next_cell(bit [3:0] mask, int from);
         for (int c = from; c < 4; c++) if (mask[c]) return c;
         return 4;
      endfunction

      // Write the id into every concrete neighborhood of every variant
      function void store_pattern(bit [23:0] code, bit [15:0] id);
         bit [31:0] masks;
         bit [15:0] nb;
         int        digit [8];
         int        pos;
         int        nxt;
         bit        done;
         for (int v = 0; v < 16; v++) begin
            masks = variant_cells(code, v);
            for (int i = 0; i < 8; i++) digit[i] = next_cell(masks[4*i +: 4], 0);
            done = 1'b0;
            while (!done) begin
               for (int i = 0; i < 8; i++) nb[2*i +: 2] = 2'(digit[i]);
               entry_valid[nb] = 1'b1;
               entry_id[nb]    = id;
               // advance the odometer over the allowed cells
               pos  = 0;
               done = 1'b1;
               while (pos < 8 && done) begin
                  nxt = next_cell(masks[4*pos +: 4], digit[pos] + 1);
                  if (nxt < 4) begin
                     digit[pos] = nxt;
                     done = 1'b0;
                  end else begin
                     digit[pos] = next_cell(masks[4*pos +: 4], 0);
                     pos++;
                  end
               end
            end
         end
      endfunction

      // A neighborhood that some variant of the pattern matches
      function bit [15:0] hit_code(bit [23:0] code);
         bit [31:0] masks;
         bit [15:0] nb;
         int        c;
         masks = variant_cells(code, $urandom_range(0, 15));
         for (int i = 0; i < 8; i++) begin
            c = $urandom_range(0, 3);
            while (!masks[4*i + c]) c = $urandom_range(0, 3);
            nb[2*i +: 2] = 2'(c);
         end
         return nb;
      endfunction

      // Apply a taken request word and queue the answer it must produce
      function void take_request(req_type w);
         rsp_type answer;
         bit      bad;
         answer = '0;
         op_count[w.opcode]++;
         case (w.opcode)
            OP_CLEAR: begin
               foreach (entry_valid[i]) begin
                  entry_valid[i] = 1'b0;
                  entry_id[i]    = '0;
               end
            end
            OP_REGISTER: begin
               bad = 1'b0;
               for (int i = 0; i < 8; i++) begin
                  if (w.shape_code[3*i +: 3] == SYM_INVALID) bad = 1'b1;
               end
               if (bad) begin
                  answer.symbol_error = 1'b1;
                  rejected++;
               end else begin
                  store_pattern(w.shape_code, w.shape_tag);
               end
            end
            OP_LOOKUP: begin
               if (entry_valid[w.neighborhood]) begin
                  answer.matched  = 1'b1;
                  answer.match_id = entry_id[w.neighborhood];
                  hits++;
               end
            end
            default: ;
         endcase
         awaited_answers.push_back(answer);
      endfunction

      function void report(string what, rsp_type want, rsp_type got);
         mismatches++;
         if (mismatches <= REPORT_MAX) begin
            $display("%s: expected id %h matched %b error %b, got id %h matched %b error %b",
                     what, want.match_id, want.matched, want.symbol_error,
                     got.match_id, got.matched, got.symbol_error);
         end
      endfunction

      // Compare one response word with the oldest awaited answer
      function void check_answer(rsp_type got);
         rsp_type want;
         if (awaited_answers.size() == 0) begin
            report("unexpected response word", '0, got);
         end else begin
            want = awaited_answers.pop_front();
            answers_checked++;
            if (got.match_id !== want.match_id || got.matched !== want.matched ||
                got.symbol_error !== want.symbol_error) begin
               report("response mismatch", want, got);
            end
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   req_type             req_word;
   logic                rsp_strobe;
   rsp_type             rsp_word;
   pattern_table_mirror table_mirror;
   bit [23:0]           known_patterns [$];
   int                  cycle_count;

   symmetric_wildcard_3x3_matcher dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Give up on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Check every response word at the edge that ends its cycle
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) table_mirror.check_answer(rsp_word);
   end

   function automatic req_type make_word(logic [1:0] op, logic [23:0] code,
                                         logic [15:0] id, logic [15:0] nb);
      req_type w;
      w.opcode       = op;
      w.shape_code   = code;
      w.shape_tag    = id;
      w.neighborhood = nb;
      return w;
   endfunction

   // Present a word and hold it until the block takes it
   task automatic send_word(input req_type w);
      start    <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy !== 1'b0);
      table_mirror.take_request(w);
   endtask

   task automatic idle_gap(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   initial begin
      req_type   w;
      bit [23:0] code;
      int        burst_left;
      int        pick;
      int        pos;

      table_mirror = new();
      cycle_count  = 0;
      reset        = 1'b1;
      start        = 1'b0;
      req_word     = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed opening: empty table, wildcard extremes, bad symbols, sweeps
      send_word(make_word(OP_LOOKUP, 24'h000000, 16'h0000, 16'h0000));
      send_word(make_word(OP_LOOKUP, 24'hFFFFFF, 16'hFFFF, 16'hFFFF));
      send_word(make_word(OP_REGISTER, PAT_ALL_ANY, 16'hFFFF, 16'h0000));
      send_word(make_word(OP_LOOKUP, 24'h000000, 16'h0000, 16'h0000));
      send_word(make_word(OP_LOOKUP, 24'h000000, 16'h0000, 16'hAAAA));
      send_word(make_word(OP_LOOKUP, 24'h000000, 16'h0000, 16'h5555));
      send_word(make_word(OP_LOOKUP, 24'h000000, 16'h0000, 16'hFFFF));
      send_word(make_word(OP_LOOKUP, 24'h000000, 16'h0000, 16'h0003));
      send_word(make_word(OP_REGISTER, 24'h000007, 16'h1234, 16'h0000));
      send_word(make_word(OP_REGISTER, 24'hF6DB6D, 16'h4321, 16'h0000));
      send_word(make_word(OP_REGISTER, 24'hFFFFFF, 16'hFFFF, 16'hFFFF));
      send_word(make_word(OP_UNUSED, 24'hFFFFFF, 16'hFFFF, 16'hFFFF));
      send_word(make_word(OP_UNUSED, 24'h000000, 16'h0000, 16'h0000));
      idle_gap(3);
      send_word(make_word(OP_CLEAR, 24'hFFFFFF, 16'hFFFF, 16'hFFFF));
      send_word(make_word(OP_LOOKUP, 24'h000000, 16'h0000, 16'h0000));
      send_word(make_word(OP_REGISTER, PAT_ALL_BORDER, 16'h0000, 16'h0000));
      send_word(make_word(OP_LOOKUP, 24'h000000, 16'h0000, 16'hFFFF));
      send_word(make_word(OP_REGISTER, PAT_MIXED, 16'h1234, 16'h0000));
      known_patterns.push_back(PAT_MIXED);
      repeat (3) begin
         send_word(make_word(OP_LOOKUP, 24'h000000, 16'h0000,
                             table_mirror.hit_code(PAT_MIXED)));
      end
      send_word(make_word(OP_REGISTER, 24'h000000, 16'h8001, 16'h0000));
      known_patterns.push_back(24'h000000);
      send_word(make_word(OP_LOOKUP, 24'h000000, 16'h0000, 16'h5555));
      send_word(make_word(OP_LOOKUP, 24'h000000, 16'h0000, 16'hAAAA));

      // Random part: look-ups in bursts, a few sweeps spaced across the run
      burst_left = 0;
      for (int k = 0; k < RANDOM_WORDS; k++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 6));
         end
         burst_left--;
         w = make_word(OP_LOOKUP, 24'($urandom), 16'($urandom), 16'($urandom));
         if (k % SWEEP_SPACING == SWEEP_SPACING / 2) begin
            if (k == CLEAR_SLOT) begin
               w.opcode = OP_CLEAR;
            end else begin
               for (int i = 0; i < 8; i++) code[3*i +: 3] = 3'($urandom_range(0, 6));
               w.opcode     = OP_REGISTER;
               w.shape_code = code;
               known_patterns.push_back(code);
            end
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
               // corrupt one symbol so the pattern is rejected
               pos = $urandom_range(0, 7);
               w.opcode = OP_REGISTER;
               w.shape_code[3*pos +: 3] = SYM_INVALID;
            end else if (pick < 13) begin
               w.opcode = OP_UNUSED;
            end else if (pick < 60) begin
               w.neighborhood = table_mirror.hit_code(
                  known_patterns[$urandom_range(0, known_patterns.size() - 1)]);
            end
         end
         send_word(w);
      end

      // Drain: wait for every owed answer, then a few quiet cycles
      start <= 1'b0;
      while (table_mirror.awaited_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d look-ups (%0d hits), %0d registrations (%0d rejected),",
               table_mirror.op_count[OP_LOOKUP], table_mirror.hits,
               table_mirror.op_count[OP_REGISTER], table_mirror.rejected);
      $display("  %0d clears, %0d unused-opcode words",
               table_mirror.op_count[OP_CLEAR], table_mirror.op_count[OP_UNUSED]);
      $display("%0d response words checked, %0d mismatches",
               table_mirror.answers_checked, table_mirror.mismatches);
      if (table_mirror.mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== symmetric_wildcard_3x3_matcher.f =====
design/swm_pkg.sv
design/swm_ram.sv
design/swm_ctrl.sv
design/swm_datapath.sv
design/symmetric_wildcard_3x3_matcher.sv
bench/symmetric_wildcard_3x3_matcher_tb.sv
